FILE: sv/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

    // Field widths of the command and response channels
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ROW_FW     = 5;
    localparam int COL_FW     = 7;
    localparam int CELL_W     = 16;
    localparam int ATTR_W     = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEWLINE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

    // Configuration register index, taken from paddr[2]
    localparam logic REG_TEXT_ATTRIBUTE = 1'b0;
    localparam int   APB_ADDR_W         = 3;
    localparam int   APB_DATA_W         = 32;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_FW-1:0] read_row;
        logic [COL_FW-1:0] read_column;
    } tcw_cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_word;
        logic [ROW_FW-1:0] cursor_row;
        logic [COL_FW-1:0] cursor_column;
    } tcw_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic sweep;
        logic load_out;
    } tcw_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] op_cmd;
        logic             scroll;
        logic             sweep_last;
        logic             out_free;
    } tcw_sts_t;

endpackage

FILE: sv/tcw_stream_if.sv
// Valid/ready stream channel carrying one payload type.
interface tcw_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/text_console_writer_unit.sv
// Top level of the text console writer: APB attribute register, controller and datapath.
//
//  Channel  Direction  Handshake          Payload
//  cmd      in         valid/ready        command, char_code, read_row, read_column
//  rsp      out        valid/ready        cell_word, cursor_row, cursor_column
//  apb      in         psel/penable       text_attribute at byte address 0
//
// Put character and newline finish in EXEC, read cell in RDATA after EXEC.
// A scroll adds a sweep of COLUMNS cells to clear the new bottom row; clear screen
// sweeps all ROWS*COLUMNS cells. Both use the single write port of the cell memory.
// After reset all ROWS*COLUMNS cells of the cell memory are cleared (2000 at the
// defaults) with cmd.ready low. One request is in work at a time; a finished
// result sits in the output register while the next request is taken.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tcw_stream_if.sink            cmd,
    tcw_stream_if.source          rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    logic [ATTR_W-1:0] attr_reg;
    logic              reg_index;
    logic              cfg_write;
    tcw_ctl_t          ctl;
    tcw_sts_t          sts;
    tcw_cmd_t          cmd_data;
    tcw_rsp_t          rsp_data;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_index == REG_TEXT_ATTRIBUTE)
                     ? APB_DATA_W'(attr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_write && (reg_index == REG_TEXT_ATTRIBUTE))
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    assign cmd_data = cmd.payload;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tcw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .cmd_data  (cmd_data),
        .attr      (attr_reg),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp_data)
    );

    assign rsp.payload = rsp_data;
endmodule

FILE: sv/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: sv/tcw_ctrl.sv
// Controller state machine of the text console writer.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tcw_sts_t sts,
    output tcw_ctl_t ctl
);
    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_RDATA = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       finish;

    always_comb
    begin
        state_next   = state_reg;
        finish       = 1'b0;
        ctl.accept   = 1'b0;
        ctl.exec     = 1'b0;
        ctl.sweep    = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                unique case (sts.op_cmd)
                    CMD_CLEAR: state_next = ST_SWEEP;
                    CMD_READ:  state_next = ST_RDATA;
                    CMD_PUT, CMD_NEWLINE:
                    begin
                        if (sts.scroll)
                        begin
                            state_next = ST_SWEEP;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_RDATA:
            begin
                finish = 1'b1;
            end
            ST_SWEEP:
            begin
                ctl.sweep = 1'b1;
                finish    = sts.sweep_last;
            end
            ST_HOLD:
            begin
                finish = 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase

        // A finished result waits in HOLD until the output register frees up.
        ctl.load_out = finish && sts.out_free;
        if (finish)
        begin
            state_next = sts.out_free ? ST_IDLE : ST_HOLD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
endmodule

FILE: sv/tcw_dpath.sv
// Datapath: cursor, scroll offset, cell memory, clearing sweep and result register.
module tcw_dpath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_ctl_t          ctl,
    output tcw_sts_t          sts,
    input  tcw_cmd_t          cmd_data,
    input  logic [ATTR_W-1:0] attr,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tcw_rsp_t          rsp_data
);
    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [RW:0]   ROWS_X    = (RW + 1)'(ROWS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW:0]   COLS_X    = (CW + 1)'(COLUMNS);

    // Cursor and top-of-screen offset: logical row r lives in physical row
    // (r + top) mod ROWS, so a scroll only moves the offset and clears one row.
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] top_reg, top_next;
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0] sweep_last_reg, sweep_last_next;

    // Operation latched at acceptance
    logic [CMD_W-1:0]  op_cmd_reg;
    logic [CHAR_W-1:0] op_char_reg;
    logic [RW-1:0]     op_prow_reg;
    logic [CW-1:0]     op_col_reg;
    logic              op_cell_ok_reg;

    logic              rsp_valid_reg;
    logic [CELL_W-1:0] cell_word_reg;
    logic [ROW_FW-1:0] cur_row_out_reg;
    logic [COL_FW-1:0] cur_col_out_reg;

    logic          is_read;
    logic          rd_in_range;
    logic [RW-1:0] sel_row;
    logic [CW-1:0] sel_col;
    logic [RW:0]   prow_sum;
    logic [RW-1:0] prow;
    logic [AW-1:0] op_addr;
    logic [AW-1:0] clr_base;
    logic [CW:0]   col_inc;
    logic          col_wrap;
    logic          advance;
    logic          last_row;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic          ram_re;
    logic [CELL_W-1:0] ram_rdata;

    // Physical row of the addressed cell, worked out at acceptance
    assign is_read     = (cmd_data.command == CMD_READ);
    assign rd_in_range = (32'(cmd_data.read_row) < 32'(ROWS))
                      && (32'(cmd_data.read_column) < 32'(COLUMNS));
    assign sel_row  = is_read ? RW'(cmd_data.read_row) : row_reg;
    assign sel_col  = is_read ? CW'(cmd_data.read_column) : col_reg;
    assign prow_sum = {1'b0, sel_row} + {1'b0, top_reg};
    assign prow     = (prow_sum >= ROWS_X) ? RW'(prow_sum - ROWS_X) : RW'(prow_sum);

    assign op_addr  = AW'(op_prow_reg) * COLS_A + AW'(op_col_reg);
    assign clr_base = AW'(top_reg) * COLS_A;

    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign col_wrap = (col_inc == COLS_X);
    assign advance  = (op_cmd_reg == CMD_NEWLINE) || ((op_cmd_reg == CMD_PUT) && col_wrap);
    assign last_row = (row_reg == LAST_ROW);

    always_comb
    begin
        row_next        = row_reg;
        col_next        = col_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = op_addr;
        ram_wdata       = {attr, op_char_reg};

        if (ctl.exec)
        begin
            case (op_cmd_reg)
                CMD_PUT:
                begin
                    ram_we   = 1'b1;
                    col_next = col_inc[CW-1:0];
                end
                CMD_CLEAR:
                begin
                    row_next        = '0;
                    col_next        = '0;
                    top_next        = '0;
                    sweep_addr_next = '0;
                    sweep_last_next = LAST_CELL;
                end
                CMD_READ:
                begin
                    ram_re = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (advance)
            begin
                col_next = '0;
                if (last_row)
                begin
                    // The old top row becomes the new bottom row and is cleared.
                    top_next        = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                    sweep_addr_next = clr_base;
                    sweep_last_next = clr_base + COLS_A - 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
        end

        if (ctl.sweep)
        begin
            ram_we          = 1'b1;
            ram_waddr       = sweep_addr_reg;
            ram_wdata       = '0;
            sweep_addr_next = sweep_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= LAST_CELL;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            if (ctl.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The cursor is taken from its next value, since a request without a sweep
    // finishes in the same cycle that moves the cursor.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            op_cmd_reg     <= cmd_data.command;
            op_char_reg    <= cmd_data.char_code;
            op_prow_reg    <= prow;
            op_col_reg     <= sel_col;
            op_cell_ok_reg <= is_read && rd_in_range;
        end
        if (ctl.load_out)
        begin
            cell_word_reg   <= op_cell_ok_reg ? ram_rdata : '0;
            cur_row_out_reg <= ROW_FW'(row_next);
            cur_col_out_reg <= COL_FW'(col_next);
        end
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (op_addr),
        .rdata (ram_rdata)
    );

    assign sts.op_cmd     = op_cmd_reg;
    assign sts.scroll     = advance && last_row;
    assign sts.sweep_last = (sweep_addr_reg == sweep_last_reg);
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid              = rsp_valid_reg;
    assign rsp_data.cell_word     = cell_word_reg;
    assign rsp_data.cursor_row    = cur_row_out_reg;
    assign rsp_data.cursor_column = cur_col_out_reg;
endmodule
